@@ hdl/inpg_pkg.sv @@
// Shared types, constants and build-time table functions for the interference nebula
// pixel generator. No dependencies; every other file in hdl imports this package.
package inpg_pkg;

   localparam int SINE_TABLE_SIZE_DEF = 512;
   localparam int COORD_BITS_DEF      = 10;
   localparam int PALETTE_ENTRIES     = 256;
   localparam int PIXEL_BITS          = 10;
   localparam int TICK_BITS           = 9;
   localparam int INDEX_BITS          = 8;
   localparam int RGB_BITS            = 16;
   localparam int CSR_DATA_BITS       = 10;
   localparam int RIPPLE_BITS         = 5;
   // Signed ripple offset that keeps every table address non-negative.
   localparam int RIPPLE_OFFSET       = 8;
   // Extra ripple table rows beyond the coordinate range: tick, both offsets and spare.
   localparam int RIPPLE_PAD          = 528;
   localparam int CENTER_X_RESET      = 160;
   localparam int CENTER_Y_RESET      = 120;

   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] TAYLOR_DIV [10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                              64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

   typedef enum logic [0:0] {
      CSR_CENTER_X = 1'b0,
      CSR_CENTER_Y = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_x;
      logic [PIXEL_BITS-1:0] pixel_y;
      logic [TICK_BITS-1:0]  frame_tick;
   } req_type;

   typedef struct packed {
      logic [RGB_BITS-1:0]   pixel_rgb565;
      logic [INDEX_BITS-1:0] palette_index;
   } rsp_type;

   typedef logic [RGB_BITS-1:0] palette_type [PALETTE_ENTRIES];

   // Magnitude of sin(angle) in Q30 from an eleven-term series; the top bit flags a negative sine.
   function automatic logic [32:0] sin_mag(input logic [63:0] angle);
      logic [63:0] a;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic        neg;
      int          k;
      a   = angle % TWO_PI_Q30;
      neg = 1'b0;
      if (a >= PI_Q30) begin
         a   = a - PI_Q30;
         neg = 1'b1;
      end
      if (a > HALF_PI_Q30) begin
         a = PI_Q30 - a;
      end
      x2   = (a * a) >> 30;
      term = a;
      sum  = a;
      for (k = 1; k <= 10; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return {neg, sum[31:0]};
   endfunction

   // floor(base + amp * sin(angle)), clamped at zero.
   function automatic logic [63:0] wave_chan(input logic [63:0] base, input logic [63:0] amp,
                                             input logic [63:0] angle);
      logic [32:0] s;
      logic [63:0] prod;
      logic [63:0] d;
      s    = sin_mag(angle);
      prod = amp * {32'd0, s[31:0]};
      d    = (prod + ONE_Q30 - 64'd1) >> 30;
      if (!s[32]) begin
         return base + (prod >> 30);
      end
      return (d > base) ? 64'd0 : base - d;
   endfunction

   function automatic palette_type build_palette();
      palette_type pal;
      logic [63:0] r;
      logic [63:0] g;
      logic [63:0] b;
      int          i;
      for (i = 0; i < PALETTE_ENTRIES; i++) begin
         r = wave_chan(64'd80, 64'd80, (64'(i) << 30) / 64'd50);
         g = wave_chan(64'd40, 64'd40, ((64'(i) * 64'd3) << 30) / 64'd100 + ONE_Q30);
         b = wave_chan(64'd160, 64'd90,
                       ((64'(i) * 64'd15) << 30) / 64'd1000 + 64'd2 * ONE_Q30);
         if (r > 64'd255) r = 64'd255;
         if (g > 64'd255) g = 64'd255;
         if (b > 64'd255) b = 64'd255;
         pal[i] = {r[7:3], g[7:2], b[7:3]};
      end
      return pal;
   endfunction

endpackage

@@ hdl/interference_nebula_pixel_gen_core.sv @@
// Top level of the interference nebula pixel generator: centre registers and the
// arithmetic pipeline. Depends on inpg_pkg, inpg_ripple_rom, inpg_palette_stage, inpg_out_skid.
//
//  Channel   Direction  Handshake              Word
//  req_      in         req_valid / req_stall  pixel_x, pixel_y, frame_tick
//  rsp_      out        rsp_valid / rsp_stall  pixel_rgb565, palette_index
//  csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One word is taken every clock while req_stall is low; results leave via the output register.
// The depth is set by the two dependent ripple ROM reads and the palette lookup.
// Reset loads the centre registers with 160 and 120; the tables are constant and need no clearing.
// rsp_stall freezes the pipeline once the skid entry fills, through the registered full flag;
// req_stall rises with the freeze and no word is lost or repeated.
module interference_nebula_pixel_gen_core #(
   parameter int SINE_TABLE_SIZE = inpg_pkg::SINE_TABLE_SIZE_DEF,
   parameter int COORD_BITS      = inpg_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  inpg_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output inpg_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  inpg_pkg::csr_index_type             csr_index,
   input  logic [inpg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import inpg_pkg::*;

   localparam int ROM_AW   = $clog2((1 << COORD_BITS) + RIPPLE_PAD);
   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int SUM_BITS = 2 * COORD_BITS + 1;

   logic                    pipe_en;
   logic                    accept;
   logic                    skid_full;

   logic [COORD_BITS-1:0]   cx_ff;
   logic [COORD_BITS-1:0]   cx_in;
   logic [COORD_BITS-1:0]   cy_ff;
   logic [COORD_BITS-1:0]   cy_in;

   logic [COORD_BITS-1:0]   in_px;
   logic [COORD_BITS-1:0]   in_py;
   logic [ROM_AW-1:0]       row_addr;
   logic [ROM_AW-1:0]       col_addr;
   logic signed [RIPPLE_BITS-1:0] row_ripple;
   logic signed [RIPPLE_BITS-1:0] col_ripple;

   logic                    s1_valid_ff;
   logic [COORD_BITS-1:0]   s1_dx_ff;
   logic [COORD_BITS-1:0]   s1_dx_in;
   logic [COORD_BITS-1:0]   s1_dy_ff;
   logic [COORD_BITS-1:0]   s1_dy_in;
   logic [COORD_BITS-1:0]   s1_px_ff;
   logic [TICK_BITS-1:0]    s1_tick_ff;

   logic                    s2_valid_ff;
   logic [SQ_BITS-1:0]      s2_sqx_ff;
   logic [SQ_BITS-1:0]      s2_sqy_ff;
   logic [TICK_BITS-1:0]    s2_tick_ff;

   logic                    s3_valid_ff;
   logic [INDEX_BITS-1:0]   s3_idx_ff;
   logic [INDEX_BITS-1:0]   s3_idx_in;
   logic [SUM_BITS-1:0]     dist_sum;
   logic [INDEX_BITS-1:0]   wave_ext;

   logic                    pal_valid;
   rsp_type                 pal_word;

   assign csr_ready = 1'b1;
   assign pipe_en   = !skid_full;
   assign req_stall = skid_full;
   assign accept    = req_valid && pipe_en;

   // Centre registers.
   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CENTER_X: cx_in = COORD_BITS'(csr_wdata);
            CSR_CENTER_Y: cy_in = COORD_BITS'(csr_wdata);
            default: begin
               cx_in = cx_ff;
               cy_in = cy_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= COORD_BITS'(CENTER_X_RESET);
         cy_ff <= COORD_BITS'(CENTER_Y_RESET);
      end else begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
   end

   // Stage 1: distances from the centre and the row ripple read.
   assign in_px = COORD_BITS'(req_data.pixel_x);
   assign in_py = COORD_BITS'(req_data.pixel_y);

   always_comb begin
      s1_dx_in = (in_px >= cx_ff) ? in_px - cx_ff : cx_ff - in_px;
      s1_dy_in = (in_py >= cy_ff) ? in_py - cy_ff : cy_ff - in_py;
      row_addr = ROM_AW'(in_py) + ROM_AW'(req_data.frame_tick) + ROM_AW'(RIPPLE_OFFSET);
   end

   // Stage 2: squares and the column ripple read, addressed by the row ripple.
   always_comb begin
      col_addr = ROM_AW'(s1_px_ff) + ROM_AW'(s1_tick_ff) + ROM_AW'(RIPPLE_OFFSET)
               + {{(ROM_AW-RIPPLE_BITS){row_ripple[RIPPLE_BITS-1]}}, row_ripple};
   end

   // Stage 3: bits 15:8 of the sum of squares, XOR with the sign-extended ripple, plus the tick.
   always_comb begin
      dist_sum  = SUM_BITS'(s2_sqx_ff) + SUM_BITS'(s2_sqy_ff);
      wave_ext  = {{(INDEX_BITS-RIPPLE_BITS){col_ripple[RIPPLE_BITS-1]}}, col_ripple};
      s3_idx_in = (dist_sum[15:8] ^ wave_ext) + s2_tick_ff[INDEX_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_px_ff   <= in_px;
         s1_tick_ff <= req_data.frame_tick;
         s2_sqx_ff  <= s1_dx_ff * s1_dx_ff;
         s2_sqy_ff  <= s1_dy_ff * s1_dy_ff;
         s2_tick_ff <= s1_tick_ff;
         s3_idx_ff  <= s3_idx_in;
      end
   end

   inpg_ripple_rom #(
      .SINE_TABLE_SIZE (SINE_TABLE_SIZE),
      .COORD_BITS      (COORD_BITS)
   ) u_ripple_rom (
      .clock   (clock),
      .en      (pipe_en),
      .addr_a  (row_addr),
      .addr_b  (col_addr),
      .rd_a_ff (row_ripple),
      .rd_b_ff (col_ripple)
   );

   // Stage 4: palette lookup.
   inpg_palette_stage u_palette (
      .clock        (clock),
      .reset        (reset),
      .en           (pipe_en),
      .in_valid     (s3_valid_ff),
      .in_index     (s3_idx_ff),
      .out_valid_ff (pal_valid),
      .out_word_ff  (pal_word)
   );

   inpg_out_skid u_out_skid (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (pal_valid),
      .in_word      (pal_word),
      .out_stall    (rsp_stall),
      .out_valid_ff (rsp_valid),
      .out_word_ff  (rsp_data),
      .full_ff      (skid_full)
   );

   // The skid entry only fills behind a result that is being held.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid entry holds a word while the output register is empty");

   // A frozen pipeline keeps its index stage.
   a_freeze_holds_index: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(s3_idx_ff) && $stable(s3_valid_ff))
      else $error("index stage changed while the pipeline was frozen");

   // A word in the palette stage survives a freeze.
   a_freeze_keeps_tail: assert property (@(posedge clock) disable iff (reset)
      pal_valid && !pipe_en |=> pal_valid && $stable(pal_word))
      else $error("palette stage lost its word while frozen");

endmodule

@@ hdl/inpg_ripple_rom.sv @@
// Dual read port ROM of ripple values, floor(sine / 512), built at elaboration.
// Depends on inpg_pkg for the sine series and the table constants.
module inpg_ripple_rom #(
   parameter int SINE_TABLE_SIZE = inpg_pkg::SINE_TABLE_SIZE_DEF,
   parameter int COORD_BITS      = inpg_pkg::COORD_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic [$clog2((1 << COORD_BITS) + inpg_pkg::RIPPLE_PAD)-1:0] addr_a,
   input  logic [$clog2((1 << COORD_BITS) + inpg_pkg::RIPPLE_PAD)-1:0] addr_b,
   output logic signed [inpg_pkg::RIPPLE_BITS-1:0] rd_a_ff,
   output logic signed [inpg_pkg::RIPPLE_BITS-1:0] rd_b_ff
);
   import inpg_pkg::*;

   localparam int ROM_DEPTH = (1 << COORD_BITS) + RIPPLE_PAD;

   typedef logic signed [RIPPLE_BITS-1:0] ripple_array_type [ROM_DEPTH];

   // Row j holds the ripple of sine entry (j - offset) mod table size, so the
   // wrap of the sum needs no hardware.
   function automatic ripple_array_type build_ripple_rom();
      ripple_array_type rom;
      logic [63:0]      a;
      logic [32:0]      s;
      int               i;
      int               j;
      int               v;
      int               fl;
      for (j = 0; j < ROM_DEPTH; j++) begin
         i = (j + SINE_TABLE_SIZE - RIPPLE_OFFSET) % SINE_TABLE_SIZE;
         if (i == 0 || 2 * i == SINE_TABLE_SIZE) begin
            v = 0;
         end else if (4 * i == SINE_TABLE_SIZE) begin
            v = 4096;
         end else if (4 * i == 3 * SINE_TABLE_SIZE) begin
            v = -4096;
         end else begin
            a = (64'(i) * 64'd2 * PI_Q30) / SINE_TABLE_SIZE;
            s = sin_mag(a);
            v = s[32] ? -int'(s[31:18]) : int'(s[31:18]);
         end
         fl     = (v >= 0) ? v / 512 : -((511 - v) / 512);
         rom[j] = RIPPLE_BITS'(fl);
      end
      return rom;
   endfunction

   localparam ripple_array_type RIPPLE_ROM = build_ripple_rom();

   always_ff @(posedge clock) begin
      if (en) begin
         rd_a_ff <= RIPPLE_ROM[addr_a];
         rd_b_ff <= RIPPLE_ROM[addr_b];
      end
   end

endmodule

@@ hdl/inpg_palette_stage.sv @@
// Final pipeline stage: registered lookup of the RGB565 palette.
// Depends on inpg_pkg for the palette builder and the result word type.
module inpg_palette_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [inpg_pkg::INDEX_BITS-1:0]   in_index,
   output logic                              out_valid_ff,
   output inpg_pkg::rsp_type                 out_word_ff
);
   import inpg_pkg::*;

   localparam palette_type PALETTE = build_palette();

   rsp_type word_in;

   always_comb begin
      word_in.pixel_rgb565  = PALETTE[in_index];
      word_in.palette_index = in_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_word_ff <= word_in;
      end
   end

endmodule

@@ hdl/inpg_out_skid.sv @@
// Output register with one skid entry, so the pipeline freeze is driven from a flop.
// Depends on inpg_pkg for the result word type.
module inpg_out_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  inpg_pkg::rsp_type in_word,
   input  logic              out_stall,
   output logic              out_valid_ff,
   output inpg_pkg::rsp_type out_word_ff,
   output logic              full_ff
);
   import inpg_pkg::*;

   logic    push;
   logic    out_free;
   logic    out_valid_in;
   logic    full_in;
   rsp_type out_word_in;
   rsp_type skid_word_ff;

   // The pipeline only moves while the skid entry is empty.
   assign push     = in_valid && !full_ff;
   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      full_in      = full_ff;
      if (out_free) begin
         if (full_ff) begin
            out_valid_in = 1'b1;
            out_word_in  = skid_word_ff;
            full_in      = 1'b0;
         end else begin
            out_valid_in = push;
            out_word_in  = in_word;
         end
      end else if (push) begin
         full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         full_ff      <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
      if (push && !out_free) begin
         skid_word_ff <= in_word;
      end
   end

endmodule
